[src/sbcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_pkg
// Shared widths, register indexes and types of the stereo bit-crusher and
// sample-rate reducer.
// ----------------------------------------------------------------------------
package sbcd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int STEP_W      = 25;
  localparam int DEPTH_W     = 5;
  localparam int MIX_W       = 17;
  localparam int PHASE_W     = 26;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = STEP_W;
  localparam int FRAC_SHIFT  = 16;
  localparam int PHASE_ONE   = 1 << FRAC_SHIFT;
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL = 2'd2;

  localparam logic [STEP_W-1:0]  HOLD_STEP_RESET = STEP_W'(PHASE_ONE);
  localparam logic [DEPTH_W-1:0] BIT_DEPTH_RESET = 5'd16;
  localparam logic [MIX_W-1:0]   MIX_LEVEL_RESET = MIX_W'(PHASE_ONE);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef struct packed {
    logic [STEP_W-1:0]  hold_step;
    logic [DEPTH_W-1:0] bit_depth;
    logic [MIX_W-1:0]   mix_level;
  } cfg_t;

endpackage
`default_nettype wire

[src/sbcd_hold.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_hold
// Phase accumulator and zero-order hold; captures the dry and held frame of
// each accepted beat into the stage register.
// ----------------------------------------------------------------------------
module sbcd_hold (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          accept,
  input  sbcd_pkg::frame_t             dry_in,
  input  wire [sbcd_pkg::STEP_W-1:0]   hold_step,
  output sbcd_pkg::frame_t             dry,
  output sbcd_pkg::frame_t             held
);
  import sbcd_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] step_eff;
  logic [PHASE_W-1:0] phase_next;
  logic               take;
  frame_t             hold;
  frame_t             hold_next;

  always_comb begin
    // clamp steps below one frame to one frame
    if (hold_step[STEP_W-1:FRAC_SHIFT] == '0) begin
      step_eff = PHASE_W'(PHASE_ONE);
    end else begin
      step_eff = PHASE_W'(hold_step);
    end
    phase_inc  = phase + PHASE_W'(PHASE_ONE);
    take       = (phase_inc >= step_eff);
    phase_next = take ? (phase_inc - step_eff) : phase_inc;
    hold_next  = take ? dry_in : hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      hold  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      hold  <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dry  <= dry_in;
      held <= hold_next;
    end
  end

endmodule
`default_nettype wire

[src/sbcd_crush_mix.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_crush_mix
// One channel: floor the held sample to the kept bit depth, then blend
// dry + floor((wet - dry) * mix / 65536).
// ----------------------------------------------------------------------------
module sbcd_crush_mix (
  input  sbcd_pkg::sample_t             dry,
  input  sbcd_pkg::sample_t             held,
  input  wire [sbcd_pkg::DEPTH_W-1:0]   bit_depth,
  input  wire [sbcd_pkg::MIX_W-1:0]     mix_level,
  output sbcd_pkg::sample_t             mixed
);
  import sbcd_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + MIX_W + 1;

  logic [DEPTH_W-1:0]            shamt;
  logic [SAMPLE_BITS-1:0]        keep_mask;
  sample_t                       wet;
  logic [MIX_W-1:0]              mix_eff;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      scaled;
  logic signed [DIFF_W-1:0]      sum;

  always_comb begin
    shamt     = DEPTH_W'(FRAC_BITS) - bit_depth;
    keep_mask = {SAMPLE_BITS{1'b1}} << shamt;
    if (bit_depth >= DEPTH_W'(FRAC_BITS)) begin
      wet = held;
    end else begin
      wet = held & keep_mask;
    end
    mix_eff = mix_level[MIX_W-1] ? MIX_W'(PHASE_ONE) : mix_level;
    diff    = {wet[SAMPLE_BITS-1], wet} - {dry[SAMPLE_BITS-1], dry};
    prod    = diff * $signed({1'b0, mix_eff});
    scaled  = prod >>> FRAC_SHIFT;
    sum     = {dry[SAMPLE_BITS-1], dry} + scaled[DIFF_W-1:0];
    mixed   = sum[SAMPLE_BITS-1:0];
  end

endmodule
`default_nettype wire

[src/stereo_bitcrush_decimator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_bitcrush_decimator
// Stereo bit-crusher and sample-rate reducer with dry/wet mix.
//
// Channel   Dir  Payload
// s_axis    in   tdata[23:0] left_sample, tdata[47:24] right_sample
// m_axis    out  tdata[23:0] left_out,    tdata[47:24] right_out
// wr        in   wr_index 0 hold_step, 1 bit_depth, 2 mix_level
//
// One frame per cycle sustained while m_axis does not stall; a beat passes the
// stage register after the hold, then the result register after the mix.
// rst clears the phase, held frame, valid flags and registers to defaults.
// A stall on m_axis holds both stages; s_axis_tready drops only when the
// stage register is full and cannot advance.
// ----------------------------------------------------------------------------
module stereo_bitcrush_decimator (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] left_sample, [47:24] right_sample
  input  wire [sbcd_pkg::TDATA_W-1:0]        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [23:0] left_out, [47:24] right_out
  output logic [sbcd_pkg::TDATA_W-1:0]       m_axis_tdata,
  input  wire                                wr_en,
  input  wire [sbcd_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire [sbcd_pkg::CFG_DATA_W-1:0]     wr_data
);
  import sbcd_pkg::*;

  cfg_t    cfg;
  frame_t  dry_in;
  frame_t  dry;
  frame_t  held;
  frame_t  mixed;
  logic    stage_valid;
  logic    stage_advance;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_step <= HOLD_STEP_RESET;
      cfg.bit_depth <= BIT_DEPTH_RESET;
      cfg.mix_level <= MIX_LEVEL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_HOLD_STEP: cfg.hold_step <= wr_data[STEP_W-1:0];
        CFG_BIT_DEPTH: cfg.bit_depth <= wr_data[DEPTH_W-1:0];
        CFG_MIX_LEVEL: cfg.mix_level <= wr_data[MIX_W-1:0];
        default:       ;
      endcase
    end
  end

  assign dry_in.left    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign dry_in.right   = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign stage_advance  = stage_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready  = !stage_valid || stage_advance;
  assign accept         = s_axis_tvalid && s_axis_tready;

  sbcd_hold u_hold (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .dry_in    (dry_in),
    .hold_step (cfg.hold_step),
    .dry       (dry),
    .held      (held)
  );

  sbcd_crush_mix u_mix_left (
    .dry       (dry.left),
    .held      (held.left),
    .bit_depth (cfg.bit_depth),
    .mix_level (cfg.mix_level),
    .mixed     (mixed.left)
  );

  sbcd_crush_mix u_mix_right (
    .dry       (dry.right),
    .held      (held.right),
    .bit_depth (cfg.bit_depth),
    .mix_level (cfg.mix_level),
    .mixed     (mixed.right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_advance) begin
        stage_valid <= 1'b0;
      end
      if (stage_advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      m_axis_tdata <= TDATA_W'({mixed.right, mixed.left});
    end
  end

endmodule
`default_nettype wire
